// ===== rtl/core/ising_metropolis_site_update_unit_assert.svh =====
// Assertion macros for the site update unit. Each one expects clk and rst_n in scope.
`ifndef ISING_METROPOLIS_SITE_UPDATE_UNIT_ASSERT_SVH
`define ISING_METROPOLIS_SITE_UPDATE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ISM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ISM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ism_pkg.sv =====
`default_nettype none
package ism_pkg;

    localparam int LATTICE_SIDE_DEFAULT = 16;
    localparam int SITE_W      = 12;
    localparam int STORE_DEPTH = 4096;
    localparam int CPL_W       = 16;
    localparam int MOMENT_W    = 16;
    localparam int COORD_W     = 6;
    localparam int NBR_W       = 18;
    localparam int NBR_CNT     = 6;
    localparam int NBR_SEL_W   = 3;
    localparam int BOND_W      = 19;
    localparam int ENERGY_W    = 24;
    localparam int THR_W       = 23;
    localparam int FIELD_W     = 16;
    localparam int POL_W       = 29;
    localparam int DELTA_W     = 18;
    localparam int POL_LIMIT   = 268435455;

    typedef enum logic
    {
        CMD_LOAD   = 1'b0,
        CMD_UPDATE = 1'b1
    } cmd_t;

    typedef enum logic [NBR_SEL_W-1:0]
    {
        NBR_UP      = 3'd0,
        NBR_DOWN    = 3'd1,
        NBR_RIGHT   = 3'd2,
        NBR_LEFT    = 3'd3,
        NBR_FORWARD = 3'd4,
        NBR_BACK    = 3'd5
    } nbr_t;

    typedef enum logic [3:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_COORD,
        ST_NBR,
        ST_MUL,
        ST_ENERGY,
        ST_LOAD_OLD,
        ST_LOAD_NEW,
        ST_DONE
    } state_t;

    typedef struct packed
    {
        logic [SITE_W-1:0]  site;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
    } coord_t;

    typedef struct packed
    {
        logic loaded;
        logic spin;
    } spin_entry_t;

    typedef struct packed
    {
        logic [NBR_CNT-1:0][CPL_W-1:0] cpl;
        logic [MOMENT_W-1:0]           moment;
    } param_t;

    // Adds a signed delta to the polarization total and clamps to the symmetric limit.
    function automatic logic signed [POL_W-1:0] pol_sat(
        input logic signed [POL_W-1:0]   acc,
        input logic signed [DELTA_W-1:0] delta
    );
        logic signed [POL_W:0] sum;
        logic signed [POL_W:0] lim;
        sum = (POL_W+1)'(acc) + (POL_W+1)'(delta);
        lim = (POL_W+1)'(POL_LIMIT);
        if (sum > lim)
        begin
            sum = lim;
        end
        else if (sum < -lim)
        begin
            sum = -lim;
        end
        return sum[POL_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ising_metropolis_site_update_unit.sv =====
// Metropolis site update unit for a random-bond Ising lattice with periodic faces.
// The input channel (in_valid / in_stall) carries one command per transaction: a load
// writes a site's six couplings, moment and spin; an update evaluates the flip energy
// of a site against its six wrapped neighbours and flips it when the energy is
// negative or no greater than flip_threshold. Every input transaction yields exactly
// one output transaction (out_valid / out_stall) with the spin, the flip flag, the
// energy and the running polarization sum.
// An update passes through the division, coordinate, neighbour, multiply and energy
// states to a registered result, a load through the old-share and new-share load states,
// and a site index outside the lattice straight to it; the unit then returns to idle.
// The update time is set by the spin memory's single read port, which fetches the seven
// spins one a cycle, plus the coordinate split and multiply. After reset the unit clears
// the spin memory to +1 and not loaded, holding in_stall high meanwhile. A stalled output
// keeps its result in the output register, and the unit still accepts and works on the next
// transaction; only the hand-off of that next result waits until the register is taken.
`default_nettype none
`include "ising_metropolis_site_update_unit_assert.svh"
module ising_metropolis_site_update_unit #(
    parameter int LATTICE_SIDE = ism_pkg::LATTICE_SIDE_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic                                command,
    input  wire logic [ism_pkg::SITE_W-1:0]          site_index,
    input  wire logic signed [ism_pkg::CPL_W-1:0]    coupling_up,
    input  wire logic signed [ism_pkg::CPL_W-1:0]    coupling_down,
    input  wire logic signed [ism_pkg::CPL_W-1:0]    coupling_right,
    input  wire logic signed [ism_pkg::CPL_W-1:0]    coupling_left,
    input  wire logic signed [ism_pkg::CPL_W-1:0]    coupling_forward,
    input  wire logic signed [ism_pkg::CPL_W-1:0]    coupling_back,
    input  wire logic [ism_pkg::MOMENT_W-1:0]        site_moment,
    input  wire logic                                initial_spin,
    input  wire logic signed [ism_pkg::FIELD_W-1:0]  field_strength,
    input  wire logic [ism_pkg::THR_W-1:0]           flip_threshold,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic                                     spin_after,
    output logic                                     flipped,
    output logic signed [ism_pkg::ENERGY_W-1:0]      energy_change,
    output logic signed [ism_pkg::POL_W-1:0]         polarization_sum
);
    import ism_pkg::*;

    localparam int SITE_COUNT = LATTICE_SIDE * LATTICE_SIDE * LATTICE_SIDE;
    // Division by the side is a multiply by a rounded-up reciprocal; exact for 12-bit sites.
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP       = ((1 << RECIP_SHIFT) + LATTICE_SIDE - 1) / LATTICE_SIDE;
    localparam int PROD_W      = SITE_W + RECIP_SHIFT + 1;
    localparam int MUL_W       = NBR_W;
    localparam int FM_W        = FIELD_W + MOMENT_W + 1;
    localparam int TOT_W       = 40;
    localparam int PARAM_W     = $bits(param_t);
    localparam int SPIN_W      = $bits(spin_entry_t);
    localparam logic signed [POL_W-1:0] POL_FORBIDDEN = {1'b1, {(POL_W-1){1'b0}}};

    // Control state.
    state_t              state_reg, state_next;
    logic [SITE_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [NBR_SEL_W-1:0] k_reg, k_next;
    logic                out_valid_reg, out_valid_next;
    logic signed [POL_W-1:0] pol_reg, pol_next;

    // Item and working payload.
    cmd_t                cmd_reg, cmd_next;
    logic [SITE_W-1:0]   site_reg, site_next;
    logic [NBR_CNT-1:0][CPL_W-1:0] cpl_reg, cpl_next;
    logic [MOMENT_W-1:0] mu_reg, mu_next;
    logic                init_spin_reg, init_spin_next;
    logic signed [FIELD_W-1:0] field_reg, field_next;
    logic [THR_W-1:0]    thr_reg, thr_next;
    logic [SITE_W-1:0]   q1_reg, q1_next;
    logic [SITE_W-1:0]   q2_reg, q2_next;
    logic [COORD_W-1:0]  x_reg, x_next;
    logic [COORD_W-1:0]  y_reg, y_next;
    logic                own_spin_reg, own_spin_next;
    logic                own_loaded_reg, own_loaded_next;
    logic                oob_reg, oob_next;
    logic signed [BOND_W-1:0] bond_reg, bond_next;
    logic signed [FM_W-1:0]   fm_reg, fm_next;
    logic                res_spin_reg, res_spin_next;
    logic                res_flip_reg, res_flip_next;
    logic signed [ENERGY_W-1:0] res_energy_reg, res_energy_next;
    logic                spin_after_reg, spin_after_next;
    logic                flipped_reg, flipped_next;
    logic signed [ENERGY_W-1:0] energy_reg, energy_next;
    logic signed [POL_W-1:0]    pol_out_reg, pol_out_next;

    // Memory ports.
    logic                spin_wr_en, spin_rd_en;
    logic [SITE_W-1:0]   spin_wr_addr, spin_rd_addr;
    spin_entry_t         spin_wr_data, spin_rd_data;
    logic                param_wr_en, param_rd_en;
    param_t              param_wr_data, param_rd_data;

    // Neighbour addressing.
    coord_t              coord;
    logic [NBR_W-1:0]    nb_addr;

    logic                accept;
    logic                in_range;
    logic [PROD_W-1:0]   prod_in, prod_q1;
    logic [MUL_W-1:0]    q1_side, q2_side;
    logic [MUL_W-1:0]    x_full, y_full;
    logic [NBR_SEL_W-1:0] term_idx;
    logic signed [BOND_W-1:0] term;
    logic                nb_pos;
    logic signed [BOND_W:0]   bond_signed;
    logic signed [FM_W:0]     fm_signed;
    logic signed [TOT_W-1:0]  total;
    logic signed [TOT_W-1:0]  energy_full;
    logic                flip;
    logic signed [DELTA_W-1:0] mu_share;

    ism_ram #(
        .WIDTH (SPIN_W),
        .DEPTH (STORE_DEPTH)
    ) u_spin_ram (
        .clk     (clk),
        .wr_en   (spin_wr_en),
        .wr_addr (spin_wr_addr),
        .wr_data (spin_wr_data),
        .rd_en   (spin_rd_en),
        .rd_addr (spin_rd_addr),
        .rd_data (spin_rd_data)
    );

    ism_ram #(
        .WIDTH (PARAM_W),
        .DEPTH (STORE_DEPTH)
    ) u_param_ram (
        .clk     (clk),
        .wr_en   (param_wr_en),
        .wr_addr (site_reg),
        .wr_data (param_wr_data),
        .rd_en   (param_rd_en),
        .rd_addr (site_index),
        .rd_data (param_rd_data)
    );

    assign coord = '{site: site_reg, x: x_reg, y: y_reg, z: q2_reg[COORD_W-1:0]};

    ism_nbr #(
        .LATTICE_SIDE (LATTICE_SIDE)
    ) u_nbr (
        .coord (coord),
        .sel   (nbr_t'(k_reg)),
        .addr  (nb_addr)
    );

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign in_range = ({{(32-SITE_W){1'b0}}, site_index} < 32'(SITE_COUNT));

    // Quotients by the side, and remainders by multiply and subtract.
    assign prod_in = PROD_W'(site_index) * PROD_W'(RECIP);
    assign prod_q1 = PROD_W'(q1_reg) * PROD_W'(RECIP);
    assign q1_side = MUL_W'(q1_reg) * MUL_W'(LATTICE_SIDE);
    assign q2_side = MUL_W'(q2_reg) * MUL_W'(LATTICE_SIDE);
    assign x_full  = MUL_W'(site_reg) - q1_side;
    assign y_full  = MUL_W'(q1_reg) - q2_side;

    // Bond term from the spin fetched last cycle; a site beyond the memory reads as +1.
    assign term_idx = k_reg - NBR_SEL_W'(1);
    assign term     = BOND_W'($signed(cpl_reg[term_idx]));
    assign nb_pos   = oob_reg || spin_rd_data.spin;

    // Energy in Q.28, rounded to Q.12 by adding half and flooring.
    assign bond_signed = own_spin_reg ? (BOND_W+1)'(bond_reg) : -(BOND_W+1)'(bond_reg);
    assign fm_signed   = own_spin_reg ? (FM_W+1)'(fm_reg) : -(FM_W+1)'(fm_reg);
    assign total       = (TOT_W'(bond_signed) <<< 18) + (TOT_W'(fm_signed) <<< 1)
                         + TOT_W'(32768);
    assign energy_full = total >>> 16;
    assign flip        = energy_full[TOT_W-1]
                         || ($signed(energy_full[ENERGY_W-1:0])
                             <= $signed({1'b0, thr_reg}));

    // Moment zero-extended to the delta width; the spin's sign is applied where it is used for load and flip shares.
    assign mu_share = DELTA_W'({2'b00, mu_reg});

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        k_next          = k_reg;
        out_valid_next  = out_valid_reg;
        pol_next        = pol_reg;
        cmd_next        = cmd_reg;
        site_next       = site_reg;
        cpl_next        = cpl_reg;
        mu_next         = mu_reg;
        init_spin_next  = init_spin_reg;
        field_next      = field_reg;
        thr_next        = thr_reg;
        q1_next         = q1_reg;
        q2_next         = q2_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        own_spin_next   = own_spin_reg;
        own_loaded_next = own_loaded_reg;
        oob_next        = oob_reg;
        bond_next       = bond_reg;
        fm_next         = fm_reg;
        res_spin_next   = res_spin_reg;
        res_flip_next   = res_flip_reg;
        res_energy_next = res_energy_reg;
        spin_after_next = spin_after_reg;
        flipped_next    = flipped_reg;
        energy_next     = energy_reg;
        pol_out_next    = pol_out_reg;

        spin_wr_en    = 1'b0;
        spin_wr_addr  = site_reg;
        spin_wr_data  = '{loaded: 1'b1, spin: init_spin_reg};
        spin_rd_en    = 1'b0;
        spin_rd_addr  = site_index;
        param_wr_en   = 1'b0;
        param_wr_data = '{cpl: cpl_reg, moment: mu_reg};
        param_rd_en   = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                spin_wr_en   = 1'b1;
                spin_wr_addr = clr_cnt_reg;
                spin_wr_data = '{loaded: 1'b0, spin: 1'b1};
                clr_cnt_next = clr_cnt_reg + SITE_W'(1);
                if (clr_cnt_reg == {SITE_W{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next       = cmd_t'(command);
                    site_next      = site_index;
                    cpl_next       = {coupling_back, coupling_forward, coupling_left,
                                      coupling_right, coupling_down, coupling_up};
                    mu_next        = site_moment;
                    init_spin_next = initial_spin;
                    field_next     = field_strength;
                    thr_next       = flip_threshold;
                    q1_next        = prod_in[RECIP_SHIFT +: SITE_W];
                    spin_rd_en     = 1'b1;
                    param_rd_en    = 1'b1;
                    if (!in_range)
                    begin
                        res_spin_next   = 1'b0;
                        res_flip_next   = 1'b0;
                        res_energy_next = '0;
                        state_next      = ST_DONE;
                    end
                    else if (cmd_t'(command) == CMD_LOAD)
                    begin
                        state_next = ST_LOAD_OLD;
                    end
                    else
                    begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                own_spin_next   = spin_rd_data.spin;
                own_loaded_next = spin_rd_data.loaded;
                cpl_next        = param_rd_data.cpl;
                mu_next         = param_rd_data.moment;
                q2_next         = prod_q1[RECIP_SHIFT +: SITE_W];
                x_next          = x_full[COORD_W-1:0];
                state_next      = ST_COORD;
            end
            ST_COORD:
            begin
                y_next     = y_full[COORD_W-1:0];
                k_next     = '0;
                bond_next  = '0;
                state_next = ST_NBR;
            end
            ST_NBR:
            begin
                // Fetch neighbour k while adding the bond of neighbour k-1.
                if (k_reg != NBR_SEL_W'(NBR_CNT))
                begin
                    spin_rd_en   = 1'b1;
                    spin_rd_addr = nb_addr[SITE_W-1:0];
                    oob_next     = (nb_addr >= NBR_W'(STORE_DEPTH));
                end
                if (k_reg != '0)
                begin
                    bond_next = nb_pos ? bond_reg + term : bond_reg - term;
                end
                k_next = k_reg + NBR_SEL_W'(1);
                if (k_reg == NBR_SEL_W'(NBR_CNT))
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                fm_next    = FM_W'(field_reg) * FM_W'($signed({1'b0, mu_reg}));
                state_next = ST_ENERGY;
            end
            ST_ENERGY:
            begin
                res_spin_next   = own_spin_reg ^ flip;
                res_flip_next   = flip;
                res_energy_next = energy_full[ENERGY_W-1:0];
                if (flip)
                begin
                    spin_wr_en   = 1'b1;
                    spin_wr_data = '{loaded: own_loaded_reg, spin: !own_spin_reg};
                    if (own_loaded_reg)
                    begin
                        pol_next = pol_sat(pol_reg, own_spin_reg ? -(mu_share <<< 1)
                                                                  : (mu_share <<< 1));
                    end
                end
                state_next = ST_DONE;
            end
            ST_LOAD_OLD:
            begin
                // Remove the old share of a site that is being reloaded.
                if (spin_rd_data.loaded)
                begin
                    pol_next = pol_sat(pol_reg,
                        spin_rd_data.spin ? -DELTA_W'({2'b00, param_rd_data.moment})
                                          : DELTA_W'({2'b00, param_rd_data.moment}));
                end
                spin_wr_en  = 1'b1;
                param_wr_en = 1'b1;
                state_next  = ST_LOAD_NEW;
            end
            ST_LOAD_NEW:
            begin
                pol_next        = pol_sat(pol_reg, init_spin_reg ? mu_share : -mu_share);
                res_spin_next   = init_spin_reg;
                res_flip_next   = 1'b0;
                res_energy_next = '0;
                state_next      = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    spin_after_next = res_spin_reg;
                    flipped_next    = res_flip_reg;
                    energy_next     = res_energy_reg;
                    pol_out_next    = pol_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            pol_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
            pol_reg       <= pol_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        site_reg       <= site_next;
        cpl_reg        <= cpl_next;
        mu_reg         <= mu_next;
        init_spin_reg  <= init_spin_next;
        field_reg      <= field_next;
        thr_reg        <= thr_next;
        q1_reg         <= q1_next;
        q2_reg         <= q2_next;
        x_reg          <= x_next;
        y_reg          <= y_next;
        own_spin_reg   <= own_spin_next;
        own_loaded_reg <= own_loaded_next;
        oob_reg        <= oob_next;
        bond_reg       <= bond_next;
        fm_reg         <= fm_next;
        res_spin_reg   <= res_spin_next;
        res_flip_reg   <= res_flip_next;
        res_energy_reg <= res_energy_next;
        spin_after_reg <= spin_after_next;
        flipped_reg    <= flipped_next;
        energy_reg     <= energy_next;
        pol_out_reg    <= pol_out_next;
    end

    assign out_valid        = out_valid_reg;
    assign spin_after       = spin_after_reg;
    assign flipped          = flipped_reg;
    assign energy_change    = energy_reg;
    assign polarization_sum = pol_out_reg;

    // An accepted transaction always takes the unit out of idle.
    `ISM_ASSERT_NXT(a_accept_busy, in_valid && !in_stall, state_reg != ST_IDLE,
                    "accepted transaction left the unit idle")
    // A negative energy must always flip, so an unflipped result has a non-negative energy.
    `ISM_ASSERT_IMP(a_noflip_energy, out_valid && !flipped, !energy_change[ENERGY_W-1],
                    "negative energy change without a flip")
    // Saturation keeps the total symmetric, so the most negative code never appears.
    `ISM_ASSERT_IMP(a_pol_range, state_reg != ST_CLEAR, pol_reg != POL_FORBIDDEN,
                    "polarization total outside its saturation range")
    // The neighbour sequencer never runs past its last bond.
    `ISM_ASSERT_IMP(a_nbr_count, state_reg == ST_NBR, k_reg <= NBR_SEL_W'(NBR_CNT),
                    "neighbour counter overran")

endmodule
`default_nettype wire

// ===== rtl/core/ism_ram.sv =====
`default_nettype none
module ism_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/ism_nbr.sv =====
`default_nettype none
module ism_nbr #(
    parameter int LATTICE_SIDE = ism_pkg::LATTICE_SIDE_DEFAULT
) (
    input  wire ism_pkg::coord_t         coord,
    input  wire ism_pkg::nbr_t           sel,
    output logic [ism_pkg::NBR_W-1:0]    addr
);
    import ism_pkg::*;

    localparam int L2 = LATTICE_SIDE * LATTICE_SIDE;
    localparam logic [NBR_W-1:0]   STEP_Z = NBR_W'(L2);
    localparam logic [NBR_W-1:0]   WRAP_Z = NBR_W'((LATTICE_SIDE - 1) * L2);
    localparam logic [NBR_W-1:0]   STEP_Y = NBR_W'(LATTICE_SIDE);
    localparam logic [NBR_W-1:0]   WRAP_Y = NBR_W'((LATTICE_SIDE - 1) * LATTICE_SIDE);
    localparam logic [NBR_W-1:0]   STEP_X = NBR_W'(1);
    localparam logic [NBR_W-1:0]   WRAP_X = NBR_W'(LATTICE_SIDE - 1);
    localparam logic [COORD_W-1:0] EDGE   = COORD_W'(LATTICE_SIDE - 1);

    logic [NBR_W-1:0] base;

    // Each neighbour steps one way along an axis and wraps at the lattice faces.
    always_comb
    begin
        base = NBR_W'(coord.site);
        unique case (sel)
            NBR_UP:      addr = (coord.z == EDGE) ? base - WRAP_Z : base + STEP_Z;
            NBR_DOWN:    addr = (coord.z == '0)   ? base + WRAP_Z : base - STEP_Z;
            NBR_RIGHT:   addr = (coord.y == EDGE) ? base - WRAP_Y : base + STEP_Y;
            NBR_LEFT:    addr = (coord.y == '0)   ? base + WRAP_Y : base - STEP_Y;
            NBR_FORWARD: addr = (coord.x == EDGE) ? base - WRAP_X : base + STEP_X;
            NBR_BACK:    addr = (coord.x == '0)   ? base + WRAP_X : base - STEP_X;
            default:     addr = base;
        endcase
    end

endmodule
`default_nettype wire
